// ===== rtl/pcbb_pkg.sv =====
package pcbb_pkg;

    // Input item opcodes.
    localparam logic [1:0] OP_ENTRY_START = 2'd0;
    localparam logic [1:0] OP_KEY_BYTE    = 2'd1;
    localparam logic [1:0] OP_VALUE_BYTE  = 2'd2;
    localparam logic [1:0] OP_TRAILER     = 2'd3;

    // Result error codes.
    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_BLOCK_FULL    = 2'd1;
    localparam logic [1:0] ERR_RESTART_FULL  = 2'd2;
    localparam logic [1:0] ERR_ORDER         = 2'd3;

    // Configuration register indexes.
    localparam int REG_RESTART_INTERVAL = 0;
    localparam logic [15:0] RESTART_INTERVAL_RESET = 16'd16;

    // Default sizes.
    localparam int DEF_MAX_KEY      = 256;
    localparam int DEF_BLOCK_BYTES  = 65536;
    localparam int DEF_MAX_RESTARTS = 1024;

    // Longest burst of results one item can cause.
    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic [8:0]  key_length;
        logic [15:0] value_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       block_last;
        logic [1:0] error;
    } out_item_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] slot;
        logic [3:0]                  count;
    } burst_t;

endpackage

// ===== rtl/pcbb_out_buffer.sv =====
module pcbb_out_buffer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pcbb_pkg::burst_t    burst,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output pcbb_pkg::out_item_t m_item
);

    pcbb_pkg::out_item_t [pcbb_pkg::MAX_RESULTS-1:0] slots_reg;
    logic [3:0]          left_reg;
    pcbb_pkg::out_item_t out_reg;
    logic                valid_reg;
    logic                move;

    // A result moves to the output register whenever that register is free.
    assign move     = (left_reg != 4'd0) && (!valid_reg || m_ready);
    assign can_load = (left_reg == 4'd0) || ((left_reg == 4'd1) && move);
    assign m_valid  = valid_reg;
    assign m_item   = out_reg;

    // Control: remaining burst count and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                left_reg <= burst.count;
            end else if (move) begin
                left_reg <= left_reg - 4'd1;
            end
            if (move) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload: burst slots shift toward the output register.
    always_ff @(posedge aclk) begin
        if (move) begin
            out_reg <= slots_reg[0];
        end
        if (load) begin
            slots_reg <= burst.slot;
        end else if (move) begin
            for (int i = 0; i < pcbb_pkg::MAX_RESULTS - 1; i++) begin
                slots_reg[i] <= slots_reg[i+1];
            end
        end
    end

endmodule

// ===== rtl/prefix_compressed_block_builder_unit.sv =====
// Prefix-compressed block builder.
// The input channel (s_valid, s_ready, s_item) takes one item per cycle
// while s_ready is high: entry starts, key bytes, value bytes and trailer
// pulls. The result channel (m_valid, m_ready, m_item) returns the encoded
// block one byte per item, with run_last on the last result of each input
// item, block_last on the final trailer byte and an error code on rejections.
// An item that causes several results holds the input while its burst
// drains through the output register; an entry header with its first
// key byte gives up to eight results. A result passes through the burst
// buffer and then the output register.
// The previous key and the restart offsets live in single-port-write
// memories that are read one entry ahead, so the key compare and the
// trailer read see their data at the cycle the item arrives.
// The user must write restart_interval through the APB port only while the
// block idles; the block itself does not enforce this. Reset empties the
// block, restores restart_interval to 16 and drops any pending results. When
// the receiver stalls, results wait in the output register and burst buffer,
// and s_ready stays low while a result waits in the burst buffer and cannot move on.
module prefix_compressed_block_builder_unit #(
    parameter int MAX_KEY      = pcbb_pkg::DEF_MAX_KEY,
    parameter int BLOCK_BYTES  = pcbb_pkg::DEF_BLOCK_BYTES,
    parameter int MAX_RESTARTS = pcbb_pkg::DEF_MAX_RESTARTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcbb_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pcbb_pkg::out_item_t m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int BW  = $clog2(BLOCK_BYTES + 1);
    localparam int RW  = $clog2(MAX_RESTARTS + 1);
    localparam int RAW = $clog2(MAX_RESTARTS);
    localparam int SW  = ((BW > 17) ? BW : 17) + 1;

    logic [8:0]  prev_kl_reg, prev_kl_next;
    logic [8:0]  cur_kl_reg, cur_kl_next;
    logic [15:0] cur_vl_reg, cur_vl_next;
    logic [8:0]  kp_reg, kp_next;
    logic [8:0]  shared_reg, shared_next;
    logic        hdr_reg, hdr_next;
    logic [15:0] esr_reg, esr_next;
    logic [BW-1:0] bytes_reg, bytes_next;
    logic [RW-1:0] rt_reg, rt_next;
    logic [RW-1:0] tp_reg, tp_next;
    logic [15:0] ri_reg;
    logic        open_reg, open_next;
    logic        share_reg, share_next;
    logic        have_reg, have_next;
    logic        eq_reg, eq_next;

    logic [7:0]    key_mem [MAX_KEY];
    logic [BW-1:0] off_mem [MAX_RESTARTS];
    logic [7:0]    key_q;
    logic [BW-1:0] off_q;
    logic          key_we, off_we;

    logic             s_fire, can_load;
    pcbb_pkg::burst_t burst;

    assign s_ready = can_load;
    assign s_fire  = s_valid && can_load;
    assign pready  = 1'b1;
    assign prdata  = (paddr == 2'd0) ? {16'd0, ri_reg} : 32'd0;

    // Header varints and an optional key byte, in emission order.
    function automatic pcbb_pkg::burst_t header_burst(
        input logic [8:0]  sh,
        input logic [8:0]  un,
        input logic [15:0] vl,
        input logic        with_data,
        input logic [7:0]  b
    );
        pcbb_pkg::burst_t r;
        logic [3:0] n;
        r = '0;
        n = 4'd0;
        if (sh >= 9'd128) begin
            r.slot[n[2:0]].out_byte = {1'b1, sh[6:0]}; n = n + 4'd1;
            r.slot[n[2:0]].out_byte = {6'd0, sh[8:7]}; n = n + 4'd1;
        end else begin
            r.slot[n[2:0]].out_byte = {1'b0, sh[6:0]}; n = n + 4'd1;
        end
        if (un >= 9'd128) begin
            r.slot[n[2:0]].out_byte = {1'b1, un[6:0]}; n = n + 4'd1;
            r.slot[n[2:0]].out_byte = {6'd0, un[8:7]}; n = n + 4'd1;
        end else begin
            r.slot[n[2:0]].out_byte = {1'b0, un[6:0]}; n = n + 4'd1;
        end
        if (vl >= 16'd16384) begin
            r.slot[n[2:0]].out_byte = {1'b1, vl[6:0]};  n = n + 4'd1;
            r.slot[n[2:0]].out_byte = {1'b1, vl[13:7]}; n = n + 4'd1;
            r.slot[n[2:0]].out_byte = {6'd0, vl[15:14]}; n = n + 4'd1;
        end else if (vl >= 16'd128) begin
            r.slot[n[2:0]].out_byte = {1'b1, vl[6:0]};  n = n + 4'd1;
            r.slot[n[2:0]].out_byte = {1'b0, vl[13:7]}; n = n + 4'd1;
        end else begin
            r.slot[n[2:0]].out_byte = {1'b0, vl[6:0]};  n = n + 4'd1;
        end
        if (with_data) begin
            r.slot[n[2:0]].out_byte = b; n = n + 4'd1;
        end
        r.count = n;
        return r;
    endfunction

    // Item decode, state update and result burst.
    always_comb begin
        logic [8:0]    k;
        logic          restart, last, eq, key_hit, final_pull, data_out;
        logic [SW-1:0] bound;
        logic [31:0]   word;
        prev_kl_next = prev_kl_reg;
        cur_kl_next  = cur_kl_reg;
        cur_vl_next  = cur_vl_reg;
        kp_next      = kp_reg;
        shared_next  = shared_reg;
        hdr_next     = hdr_reg;
        esr_next     = esr_reg;
        bytes_next   = bytes_reg;
        rt_next      = rt_reg;
        tp_next      = tp_reg;
        open_next    = open_reg;
        share_next   = share_reg;
        have_next    = have_reg;
        eq_next      = eq_reg;
        key_we       = 1'b0;
        off_we       = 1'b0;
        burst        = '0;
        data_out     = 1'b0;
        k = (32'(s_item.key_length) > 32'(MAX_KEY)) ? 9'(MAX_KEY) : s_item.key_length;
        restart = esr_reg >= ri_reg;
        bound = SW'(1) + ((k >= 9'd128) ? SW'(2) : SW'(1))
              + ((s_item.value_length >= 16'd16384) ? SW'(3)
                 : (s_item.value_length >= 16'd128) ? SW'(2) : SW'(1))
              + SW'(k) + SW'(s_item.value_length);
        last = (kp_reg + 9'd1) == cur_kl_reg;
        key_hit = (kp_reg < prev_kl_reg) && (key_q == s_item.data_byte);
        eq = eq_reg;
        final_pull = tp_reg >= rt_reg;
        word = final_pull ? 32'(rt_reg) : ((tp_reg == '0) ? 32'd0 : 32'(off_q));
        if (s_fire) begin
            case (s_item.op)
                pcbb_pkg::OP_ENTRY_START: begin
                    if (!open_reg && tp_reg == '0) begin
                        burst.count = 4'd1;
                        if (restart && rt_reg >= RW'(MAX_RESTARTS)) begin
                            burst.slot[0].error = pcbb_pkg::ERR_RESTART_FULL;
                        end else if (SW'(bytes_reg) + bound > SW'(BLOCK_BYTES)) begin
                            burst.slot[0].error = pcbb_pkg::ERR_BLOCK_FULL;
                        end else if (k == 9'd0 && have_reg) begin
                            burst.slot[0].error = pcbb_pkg::ERR_ORDER;
                        end else begin
                            burst.count = 4'd0;
                            if (restart) begin
                                off_we     = 1'b1;
                                rt_next    = rt_reg + RW'(1);
                                share_next = 1'b0;
                                esr_next   = 16'd1;
                            end else begin
                                share_next = 1'b1;
                                esr_next   = (esr_reg < 16'hFFFF) ? esr_reg + 16'd1 : esr_reg;
                            end
                            cur_kl_next = k;
                            cur_vl_next = s_item.value_length;
                            kp_next     = 9'd0;
                            shared_next = 9'd0;
                            hdr_next    = 1'b0;
                            eq_next     = have_reg;
                            open_next   = 1'b1;
                            if (k == 9'd0) begin
                                burst    = header_burst(9'd0, 9'd0, s_item.value_length,
                                                        1'b0, 8'd0);
                                data_out = 1'b1;
                                hdr_next = 1'b1;
                                if (s_item.value_length == 16'd0) begin
                                    prev_kl_next = 9'd0;
                                    have_next    = 1'b1;
                                    open_next    = 1'b0;
                                end
                            end
                        end
                    end
                end
                pcbb_pkg::OP_KEY_BYTE: begin
                    if (open_reg && kp_reg < cur_kl_reg) begin
                        if (eq && (kp_reg >= prev_kl_reg || s_item.data_byte > key_q)) begin
                            eq = 1'b0;
                        end
                        if (eq_reg && (kp_reg < prev_kl_reg) && (s_item.data_byte < key_q)) begin
                            burst.count = 4'd1;
                            burst.slot[0].error = pcbb_pkg::ERR_ORDER;
                        end else if (eq && last) begin
                            burst.count = 4'd1;
                            burst.slot[0].error = pcbb_pkg::ERR_ORDER;
                        end else begin
                            eq_next = eq;
                            data_out = 1'b1;
                            if (!hdr_reg) begin
                                if (share_reg && key_hit) begin
                                    shared_next = shared_reg + 9'd1;
                                    if (last) begin
                                        burst = header_burst(shared_reg + 9'd1,
                                                             cur_kl_reg - shared_reg - 9'd1,
                                                             cur_vl_reg, 1'b0, 8'd0);
                                        hdr_next = 1'b1;
                                    end
                                end else begin
                                    burst = header_burst(shared_reg, cur_kl_reg - shared_reg,
                                                         cur_vl_reg, 1'b1, s_item.data_byte);
                                    hdr_next = 1'b1;
                                end
                            end else begin
                                burst.count = 4'd1;
                                burst.slot[0].out_byte = s_item.data_byte;
                            end
                            key_we  = 1'b1;
                            kp_next = kp_reg + 9'd1;
                            if (last && cur_vl_reg == 16'd0) begin
                                prev_kl_next = cur_kl_reg;
                                have_next    = 1'b1;
                                open_next    = 1'b0;
                            end
                        end
                    end
                end
                pcbb_pkg::OP_VALUE_BYTE: begin
                    if (open_reg && kp_reg == cur_kl_reg && hdr_reg && cur_vl_reg != 16'd0) begin
                        burst.count = 4'd1;
                        burst.slot[0].out_byte = s_item.data_byte;
                        data_out = 1'b1;
                        cur_vl_next = cur_vl_reg - 16'd1;
                        if (cur_vl_reg == 16'd1) begin
                            prev_kl_next = cur_kl_reg;
                            have_next    = 1'b1;
                            open_next    = 1'b0;
                        end
                    end
                end
                pcbb_pkg::OP_TRAILER: begin
                    if (!open_reg) begin
                        burst.count = 4'd4;
                        for (int j = 0; j < 4; j++) begin
                            burst.slot[j].out_byte = word[8*j +: 8];
                        end
                        burst.slot[3].block_last = final_pull;
                        if (final_pull) begin
                            prev_kl_next = 9'd0;
                            have_next    = 1'b0;
                            esr_next     = 16'd0;
                            bytes_next   = '0;
                            rt_next      = RW'(1);
                            tp_next      = '0;
                        end else begin
                            tp_next = tp_reg + RW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (data_out) begin
            bytes_next = bytes_reg + BW'(burst.count);
        end
        if (burst.count != 4'd0) begin
            burst.slot[3'(burst.count - 4'd1)].run_last = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_kl_reg <= 9'd0;
            cur_kl_reg  <= 9'd0;
            cur_vl_reg  <= 16'd0;
            kp_reg      <= 9'd0;
            shared_reg  <= 9'd0;
            hdr_reg     <= 1'b0;
            esr_reg     <= 16'd0;
            bytes_reg   <= '0;
            rt_reg      <= RW'(1);
            tp_reg      <= '0;
            open_reg    <= 1'b0;
            share_reg   <= 1'b0;
            have_reg    <= 1'b0;
            eq_reg      <= 1'b0;
            ri_reg      <= pcbb_pkg::RESTART_INTERVAL_RESET;
        end else begin
            prev_kl_reg <= prev_kl_next;
            cur_kl_reg  <= cur_kl_next;
            cur_vl_reg  <= cur_vl_next;
            kp_reg      <= kp_next;
            shared_reg  <= shared_next;
            hdr_reg     <= hdr_next;
            esr_reg     <= esr_next;
            bytes_reg   <= bytes_next;
            rt_reg      <= rt_next;
            tp_reg      <= tp_next;
            open_reg    <= open_next;
            share_reg   <= share_next;
            have_reg    <= have_next;
            eq_reg      <= eq_next;
            if (psel && penable && pwrite) begin
                ri_reg <= pwdata[15:0];
            end
        end
    end

    // Previous key memory, read one position ahead of the key byte.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[KAW'(kp_reg)] <= s_item.data_byte;
        end
        key_q <= key_mem[KAW'(kp_next)];
    end

    // Restart offset memory, read one trailer position ahead.
    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[RAW'(rt_reg)] <= bytes_reg;
        end
        off_q <= off_mem[RAW'(tp_next)];
    end

    pcbb_out_buffer u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== rtl/pcbb_checker.sv =====
module pcbb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input pcbb_pkg::out_item_t m_item
);

    // The final trailer byte always ends its item's burst.
    a_block_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.block_last |-> m_item.run_last)
        else $error("block_last without run_last");

    // A rejection is a lone zero status result.
    a_error_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.error != pcbb_pkg::ERR_NONE |->
            m_item.run_last && m_item.out_byte == 8'd0 && !m_item.block_last)
        else $error("malformed error result");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

endmodule

bind prefix_compressed_block_builder_unit pcbb_checker u_pcbb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== tb/prefix_compressed_block_builder_unit_test.sv =====
module prefix_compressed_block_builder_unit_test;
    import pcbb_pkg::*;

    localparam int KEY_CAP     = DEF_MAX_KEY;
    localparam int BLOCK_CAP   = DEF_BLOCK_BYTES;
    localparam int RESTART_CAP = DEF_MAX_RESTARTS;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    prefix_compressed_block_builder_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Mirror of the block state used to predict the encoded bytes.
    logic [7:0] prior_key [KEY_CAP];
    int         last_key_len;
    int         key_len;
    int         value_left;
    int         key_pos;
    int         shared_len;
    bit         header_done;
    int         entries_in_run;
    int         block_size;
    int         restart_at [RESTART_CAP];
    int         restart_count;
    int         trailer_pos;
    int         interval;
    bit         entry_open;
    bit         may_share;
    bit         has_last_key;
    bit         key_tied;

    out_item_t  burst [$];
    out_item_t  expected_bytes [$];
    bit         took;
    int         taken;
    int         failures;
    int         send_idle;
    int         recv_idle;
    int         quiet;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t fixed;
    } dir_row_t;

    dir_row_t rows [$];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic in_item_t mk(logic [1:0] op, logic [7:0] b, logic [8:0] kl,
                                    logic [15:0] vl);
        in_item_t it;
        it.op = op;
        it.data_byte = b;
        it.key_length = kl;
        it.value_length = vl;
        return it;
    endfunction

    function automatic int varint_len(int v);
        int n;
        n = 1;
        while (v >= 128) begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit blk, logic [1:0] err);
        out_item_t r;
        r.out_byte = b;
        r.run_last = 1'b0;
        r.block_last = blk;
        r.error = err;
        burst.push_back(r);
    endfunction

    function automatic void push_data(logic [7:0] b);
        push_byte(b, 1'b0, ERR_NONE);
        block_size++;
    endfunction

    function automatic void push_varint(int v);
        while (v >= 128) begin
            push_data(8'((v & 127) | 128));
            v = v >> 7;
        end
        push_data(8'(v));
    endfunction

    function automatic void send_header();
        push_varint(shared_len);
        push_varint(key_len - shared_len);
        push_varint(value_left);
        header_done = 1'b1;
    endfunction

    function automatic void close_record();
        last_key_len = key_len;
        has_last_key = 1'b1;
        entry_open = 1'b0;
    endfunction

    function automatic void empty_block();
        last_key_len = 0;
        has_last_key = 1'b0;
        entries_in_run = 0;
        block_size = 0;
        restart_at[0] = 0;
        restart_count = 1;
        trailer_pos = 0;
    endfunction

    // Compute the bytes one accepted item produces and advance the mirror.
    function automatic void encode_item(in_item_t it);
        int         k;
        int         bound;
        int         i;
        bit         restart;
        bit         last;
        bit         eq;
        bit         byte_hit;
        bit         final_word;
        logic [31:0] word;
        burst.delete();
        took = 1'b1;
        case (it.op)
            OP_ENTRY_START: begin
                k = (it.key_length > KEY_CAP) ? KEY_CAP : int'(it.key_length);
                restart = entries_in_run >= interval;
                bound = 1 + varint_len(k) + varint_len(it.value_length) + k
                        + int'(it.value_length);
                if (entry_open || trailer_pos != 0) begin
                    took = 1'b0;
                end else if (restart && restart_count >= RESTART_CAP) begin
                    push_byte(8'd0, 1'b0, ERR_RESTART_FULL);
                end else if (block_size + bound > BLOCK_CAP) begin
                    push_byte(8'd0, 1'b0, ERR_BLOCK_FULL);
                end else if (k == 0 && has_last_key) begin
                    push_byte(8'd0, 1'b0, ERR_ORDER);
                end else begin
                    if (restart) begin
                        restart_at[restart_count] = block_size;
                        restart_count++;
                        entries_in_run = 0;
                        may_share = 1'b0;
                    end else begin
                        may_share = 1'b1;
                    end
                    if (entries_in_run < 16'hFFFF) entries_in_run++;
                    key_len = k;
                    value_left = it.value_length;
                    key_pos = 0;
                    shared_len = 0;
                    header_done = 1'b0;
                    key_tied = has_last_key;
                    entry_open = 1'b1;
                    if (k == 0) begin
                        send_header();
                        if (value_left == 0) close_record();
                    end
                end
            end
            OP_KEY_BYTE: begin
                i = key_pos;
                if (!entry_open || i >= key_len || i >= KEY_CAP) begin
                    took = 1'b0;
                end else begin
                    last = (i + 1 == key_len);
                    byte_hit = (i < last_key_len) && (prior_key[i] == it.data_byte);
                    eq = key_tied;
                    if (eq) begin
                        if (i >= last_key_len) eq = 1'b0;
                        else if (it.data_byte < prior_key[i]) begin
                            push_byte(8'd0, 1'b0, ERR_ORDER);
                            eq = 1'b1;
                            last = 1'b0;
                            byte_hit = 1'b0;
                            i = -1;
                        end else if (it.data_byte > prior_key[i]) eq = 1'b0;
                    end
                    if (i < 0) begin
                        // Smaller key byte: rejected without effect.
                    end else if (eq && last) begin
                        push_byte(8'd0, 1'b0, ERR_ORDER);
                    end else begin
                        key_tied = eq;
                        if (!header_done) begin
                            if (may_share && byte_hit) begin
                                shared_len++;
                                if (last) send_header();
                            end else begin
                                send_header();
                                push_data(it.data_byte);
                            end
                        end else begin
                            push_data(it.data_byte);
                        end
                        prior_key[i] = it.data_byte;
                        key_pos = i + 1;
                        if (last && value_left == 0) close_record();
                    end
                end
            end
            OP_VALUE_BYTE: begin
                if (!entry_open || key_pos != key_len || !header_done || value_left == 0) begin
                    took = 1'b0;
                end else begin
                    push_data(it.data_byte);
                    value_left--;
                    if (value_left == 0) close_record();
                end
            end
            default: begin
                if (entry_open) begin
                    took = 1'b0;
                end else begin
                    final_word = trailer_pos >= restart_count;
                    if (!final_word && trailer_pos < RESTART_CAP)
                        word = 32'(restart_at[trailer_pos]);
                    else
                        word = 32'(restart_count);
                    for (int j = 0; j < 4; j++)
                        push_byte(word[8*j +: 8], final_word && j == 3, ERR_NONE);
                    if (final_word) empty_block();
                    else trailer_pos++;
                end
            end
        endcase
        if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        failures++;
    endtask

    // Offer one item, wait for it to be taken, then queue its predicted bytes.
    task automatic send_item(in_item_t it, bit typed, out_item_t fixed);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        encode_item(it);
        if (typed) expected_bytes.push_back(fixed);
        else foreach (burst[k]) expected_bytes.push_back(burst[k]);
        if (took) taken++;
        @(negedge aclk);
    endtask

    // Stop offering items until every predicted byte is out, then let it settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(int idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(4 * idx);
        pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_RESTART_INTERVAL) interval = int'(v[15:0]);
    endtask

    // Key bytes that mostly keep the order, sharing with the previous key.
    function automatic logic [7:0] pick_key_byte(bit noisy);
        bit last;
        if (noisy) return 8'($urandom_range(255));
        if (key_tied && key_pos < last_key_len) begin
            last = (key_pos + 1 == key_len);
            if (prior_key[key_pos] == 8'hFF) return 8'hFF;
            if (!last && $urandom_range(9) < 7) return prior_key[key_pos];
            return 8'($urandom_range(255, int'(prior_key[key_pos]) + 1));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic close_entry();
        int guard;
        guard = 0;
        while (entry_open && guard < 800) begin
            guard++;
            if (key_pos < key_len)
                send_item(mk(OP_KEY_BYTE, pick_key_byte($urandom_range(19) == 0), 9'd0, 16'd0),
                          1'b0, '0);
            else
                send_item(mk(OP_VALUE_BYTE, 8'($urandom_range(255)), 9'd0, 16'd0), 1'b0, '0);
        end
    endtask

    task automatic pull_trailer();
        do begin
            send_item(mk(OP_TRAILER, 8'($urandom_range(255)), 9'($urandom_range(511)),
                         16'($urandom_range(65535))), 1'b0, '0);
        end while (trailer_pos != 0 && !entry_open);
    endtask

    task automatic random_entry();
        int r;
        int kl;
        int vl;
        r = $urandom_range(99);
        if (r < 2) kl = $urandom_range(140, 128);
        else if (r < 5) kl = 0;
        else kl = $urandom_range(6, 1);
        vl = ($urandom_range(99) < 5) ? $urandom_range(140, 128) : $urandom_range(5);
        send_item(mk(OP_ENTRY_START, 8'($urandom_range(255)), 9'(kl), 16'(vl)), 1'b0, '0);
        close_entry();
    endtask

    // Misplaced and malformed items, then a return to a clean state.
    task automatic noise();
        int kl;
        int vl;
        repeat ($urandom_range(3, 1)) begin
            kl = ($urandom_range(9) == 0) ? $urandom_range(140, 129) : $urandom_range(4);
            vl = ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(65535, 65000);
            send_item(mk(2'($urandom_range(3)), 8'($urandom_range(255)), 9'(kl), 16'(vl)),
                      1'b0, '0);
        end
        close_entry();
        if (trailer_pos != 0) pull_trailer();
    endtask

    task automatic run_phase(int si, int ri, int ival);
        int r;
        drain();
        write_cfg(REG_RESTART_INTERVAL, 32'(ival));
        send_idle = si;
        recv_idle = ri;
        taken = 0;
        while (taken < 75) begin
            r = $urandom_range(99);
            if (r < 75) random_entry();
            else if (r < 85) pull_trailer();
            else noise();
        end
    endtask

    task automatic add_row(logic [1:0] op, logic [7:0] b, logic [8:0] kl, logic [15:0] vl,
                           bit typed, logic [1:0] err);
        dir_row_t row;
        row.it = mk(op, b, kl, vl);
        row.typed = typed;
        row.fixed.out_byte = 8'd0;
        row.fixed.run_last = 1'b1;
        row.fixed.block_last = 1'b0;
        row.fixed.error = err;
        rows.push_back(row);
    endtask

    // Receiver side: random stalls applied at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Compare each delivered byte with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report("unexpected item", int'(m_item), 0);
            end else begin
                want = expected_bytes.pop_front();
                if (m_item.out_byte !== want.out_byte)
                    report("out_byte", m_item.out_byte, want.out_byte);
                if (m_item.run_last !== want.run_last)
                    report("run_last", m_item.run_last, want.run_last);
                if (m_item.block_last !== want.block_last)
                    report("block_last", m_item.block_last, want.block_last);
                if (m_item.error !== want.error)
                    report("error", m_item.error, want.error);
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        failures = 0;
        quiet = 0;
        send_idle = 16;
        recv_idle = 63;
        taken = 0;
        entry_open = 1'b0;
        may_share = 1'b0;
        key_tied = 1'b0;
        key_len = 0;
        value_left = 0;
        key_pos = 0;
        shared_len = 0;
        header_done = 1'b0;
        interval = int'(RESTART_INTERVAL_RESET);
        empty_block();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed items against the reset configuration.
        add_row(OP_TRAILER, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_TRAILER, 8'hFF, 9'h1FF, 16'hFFFF, 1'b0, ERR_NONE);
        add_row(OP_ENTRY_START, 8'h00, 9'd0, 16'hFFFF, 1'b1, ERR_BLOCK_FULL);
        add_row(OP_ENTRY_START, 8'h00, 9'h1FF, 16'hFFFF, 1'b1, ERR_BLOCK_FULL);
        add_row(OP_KEY_BYTE, 8'hAA, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_ENTRY_START, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_ENTRY_START, 8'h00, 9'd0, 16'd0, 1'b1, ERR_ORDER);
        add_row(OP_ENTRY_START, 8'h00, 9'd3, 16'd2, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'hFF, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'h10, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_TRAILER, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_VALUE_BYTE, 8'hFF, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_VALUE_BYTE, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_VALUE_BYTE, 8'h5A, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_ENTRY_START, 8'h00, 9'd3, 16'd1, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'hFF, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_KEY_BYTE, 8'h05, 9'd0, 16'd0, 1'b1, ERR_ORDER);
        add_row(OP_KEY_BYTE, 8'h10, 9'd0, 16'd0, 1'b1, ERR_ORDER);
        add_row(OP_KEY_BYTE, 8'h20, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_VALUE_BYTE, 8'h7F, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_TRAILER, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        add_row(OP_TRAILER, 8'h00, 9'd0, 16'd0, 1'b0, ERR_NONE);
        foreach (rows[n]) send_item(rows[n].it, rows[n].typed, rows[n].fixed);

        // Random traffic under each idling pattern and interval setting.
        run_phase(16, 63, 1);
        run_phase(63, 16, 0);
        run_phase(0, 0, 65535);

        // Finish the open block and wait for every result.
        drain();
        close_entry();
        pull_trailer();
        drain();

        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcbb_pkg.sv
rtl/pcbb_out_buffer.sv
rtl/prefix_compressed_block_builder_unit.sv
rtl/pcbb_checker.sv
tb/prefix_compressed_block_builder_unit_test.sv
